// ----- src/gel_pkg.sv -----
// Package with shared types and constants of the grid expansion and locate block.
`timescale 1ns / 1ps

package gel_pkg;

    localparam int DEF_MAX_COLUMNS = 4096;
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_MAX_CELLS   = 16777216;

    localparam logic [2:0] REG_EXPANDABLE = 3'd0;
    localparam logic [2:0] REG_RESOLUTION = 3'd1;
    localparam logic [2:0] REG_MARGIN     = 3'd2;
    localparam logic [2:0] REG_INCREMENT  = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X   = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd5;
    localparam logic [2:0] REG_INIT_COLS  = 3'd6;
    localparam logic [2:0] REG_INIT_ROWS  = 3'd7;

    localparam logic [1:0] OC_UNCHANGED = 2'd0;
    localparam logic [1:0] OC_EXPANDED  = 2'd1;
    localparam logic [1:0] OC_FIXED_REJ = 2'd2;
    localparam logic [1:0] OC_LIMIT_REJ = 2'd3;

    localparam int MUL_STEPS = 31;
    localparam int DIV_STEPS = 36;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } in_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic               cell_valid;
        logic [23:0]        cell_index;
        logic [12:0]        grid_columns;
        logic [12:0]        grid_rows;
        logic signed [31:0] grid_min_x;
        logic signed [31:0] grid_min_y;
        logic [31:0]        grid_revision;
    } out_t;

endpackage

// ----- src/grid_expand_and_locate.sv -----
// Top level of the grid expansion and point locate block.
`timescale 1ns / 1ps

// Usage: configure the grid through the APB-style port while the block is idle;
// writes to the origin and initial count registers also load the live grid.
// Each request on the s_ channel carries one point in signed Q16.16 metres.
// The block may grow the grid around the point and then returns one result on
// the m_ channel: outcome, cell index, and the grid geometry after the request.
// All products and quotients go through one shared bit-serial add/subtract unit.
// Without growth, a request computes the grid extent and, when the point ends up
// inside the grid, its column, row and cell index.
// Each side that grows adds two round-up divides and a multiply, and growth
// then adds the area check and the corner update.
// The block takes one request at a time; s_ready is high only while idle.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled receiver only delays the end of that request.
// Reset is synchronous and active low; it loads the default configuration
// and the default grid, with the revision set to one.
module grid_expand_and_locate #(
    parameter int MAX_COLUMNS = gel_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gel_pkg::DEF_MAX_ROWS,
    parameter int MAX_CELLS   = gel_pkg::DEF_MAX_CELLS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gel_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gel_pkg::out_t m_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int CW0 = $clog2(MAX_COLUMNS + 1);
    localparam int CW1 = $clog2(MAX_ROWS + 1);
    localparam int CWM = (CW0 > CW1) ? CW0 : CW1;
    localparam int CW  = (CWM > 13) ? CWM : 13;
    localparam int AW  = 48;
    localparam int SW  = 50;
    localparam int QW  = 36;
    localparam int NW  = 38;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_MAXX   = 5'd1;
    localparam logic [4:0] ST_MAXY   = 5'd2;
    localparam logic [4:0] ST_EVAL   = 5'd3;
    localparam logic [4:0] ST_NEED   = 5'd4;
    localparam logic [4:0] ST_ROUND  = 5'd5;
    localparam logic [4:0] ST_SCALE  = 5'd6;
    localparam logic [4:0] ST_SUM    = 5'd7;
    localparam logic [4:0] ST_AREA   = 5'd8;
    localparam logic [4:0] ST_SHX    = 5'd9;
    localparam logic [4:0] ST_SHY    = 5'd10;
    localparam logic [4:0] ST_COMMIT = 5'd11;
    localparam logic [4:0] ST_LMAXX  = 5'd12;
    localparam logic [4:0] ST_LMAXY  = 5'd13;
    localparam logic [4:0] ST_LCHK   = 5'd14;
    localparam logic [4:0] ST_COL    = 5'd15;
    localparam logic [4:0] ST_ROW    = 5'd16;
    localparam logic [4:0] ST_IDX    = 5'd17;
    localparam logic [4:0] ST_OUT    = 5'd18;

    localparam logic signed [SW-1:0] CORNER_MIN = {{(SW-31){1'b1}}, 31'd0};
    localparam logic [NW-1:0] LIM_COLS  = NW'(MAX_COLUMNS);
    localparam logic [NW-1:0] LIM_ROWS  = NW'(MAX_ROWS);
    localparam logic [AW-1:0] LIM_CELLS = AW'(MAX_CELLS);

    logic               exp_reg;
    logic [30:0]        res_reg;
    logic [30:0]        margin_reg;
    logic [12:0]        inc_reg;
    logic [31:0]        orgx_reg;
    logic [31:0]        orgy_reg;
    logic [12:0]        icol_reg;
    logic [12:0]        irow_reg;

    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic [CW-1:0]      ct_reg;
    logic [CW-1:0]      rt_reg;
    logic [31:0]        rev_reg;

    logic [4:0]         state_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [SW-1:0] maxx_reg;
    logic signed [SW-1:0] maxy_reg;
    logic signed [SW-1:0] amt_reg [4];
    logic [QW-1:0]      cells_reg [4];
    logic [1:0]         k_reg;
    logic [QW-1:0]      tmp_reg;
    logic [QW-1:0]      col_reg;
    logic [NW-1:0]      nc_reg;
    logic [NW-1:0]      nr_reg;
    logic signed [SW-1:0] nx_reg;
    logic signed [SW-1:0] ny_reg;
    logic [1:0]         outcome_reg;
    logic               cv_reg;
    logic [23:0]        ci_reg;

    logic               run_reg;
    logic               mode_mul_reg;
    logic [5:0]         cnt_reg;
    logic [AW-1:0]      acc_reg;
    logic [AW-1:0]      opa_reg;
    logic [QW-1:0]      opb_reg;

    logic               m_valid_reg;
    gel_pkg::out_t      m_data_reg;

    logic               cfg_wr;
    logic [30:0]        res_eff;
    logic [12:0]        chunk_eff;
    logic signed [SW-1:0] cxe, cye, pxe, pye, mxe;
    logic               done;
    logic               ld_mul;
    logic [AW-1:0]      ld_a;
    logic [30:0]        ld_b;
    logic [31:0]        div_r2;
    logic               div_ge;
    logic [NW-1:0]      nc_sum;
    logic [NW-1:0]      nr_sum;
    logic               any_cells;
    logic               pt_in;
    logic [AW-1:0]      idx_sum;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign res_eff   = (res_reg == '0) ? 31'd1 : res_reg;
    assign chunk_eff = (inc_reg == '0) ? 13'd1 : inc_reg;
    assign cxe = SW'(cx_reg);
    assign cye = SW'(cy_reg);
    assign pxe = SW'(px_reg);
    assign pye = SW'(py_reg);
    assign mxe = $signed({{(SW-31){1'b0}}, margin_reg});
    assign done = run_reg && (cnt_reg == '0);

    assign div_r2 = {acc_reg[30:0], opb_reg[QW-1]};
    assign div_ge = div_r2 >= {1'b0, opa_reg[30:0]};

    assign nc_sum = NW'(ct_reg) + NW'(cells_reg[0]) + NW'(cells_reg[1]);
    assign nr_sum = NW'(rt_reg) + NW'(cells_reg[2]) + NW'(cells_reg[3]);
    assign any_cells = (cells_reg[0] != '0) || (cells_reg[1] != '0) ||
                       (cells_reg[2] != '0) || (cells_reg[3] != '0);
    assign pt_in = (pxe >= cxe) && (pye >= cye) && (pxe < maxx_reg) && (pye < maxy_reg);
    assign idx_sum = acc_reg + AW'(col_reg);

    always_comb begin
        case (paddr[4:2])
            gel_pkg::REG_EXPANDABLE: prdata = {31'd0, exp_reg};
            gel_pkg::REG_RESOLUTION: prdata = {1'b0, res_reg};
            gel_pkg::REG_MARGIN:     prdata = {1'b0, margin_reg};
            gel_pkg::REG_INCREMENT:  prdata = {19'd0, inc_reg};
            gel_pkg::REG_ORIGIN_X:   prdata = orgx_reg;
            gel_pkg::REG_ORIGIN_Y:   prdata = orgy_reg;
            gel_pkg::REG_INIT_COLS:  prdata = {19'd0, icol_reg};
            gel_pkg::REG_INIT_ROWS:  prdata = {19'd0, irow_reg};
            default:                 prdata = '0;
        endcase
    end

    always_comb begin
        ld_mul = 1'b1;
        ld_a   = '0;
        ld_b   = res_eff;
        case (state_reg)
            ST_MAXX, ST_LMAXX: ld_a = AW'(ct_reg);
            ST_MAXY, ST_LMAXY: ld_a = AW'(rt_reg);
            ST_NEED: begin
                ld_mul = 1'b0;
                ld_a   = AW'(amt_reg[k_reg][AW-1:0] + AW'(res_eff) - AW'(1));
            end
            ST_ROUND: begin
                ld_mul = 1'b0;
                ld_a   = AW'(tmp_reg) + AW'(chunk_eff) - AW'(1);
                ld_b   = 31'(chunk_eff);
            end
            ST_SCALE: begin
                ld_a = AW'(tmp_reg);
                ld_b = 31'(chunk_eff);
            end
            ST_AREA: begin
                ld_a = AW'(nc_reg);
                ld_b = nr_reg[30:0];
            end
            ST_SHX: ld_a = AW'(cells_reg[0]);
            ST_SHY: ld_a = AW'(cells_reg[2]);
            ST_COL: begin
                ld_mul = 1'b0;
                ld_a   = AW'(pxe - cxe);
            end
            ST_ROW: begin
                ld_mul = 1'b0;
                ld_a   = AW'(pye - cye);
            end
            ST_IDX: begin
                ld_a = AW'(tmp_reg);
                ld_b = 31'(ct_reg);
            end
            default: ld_a = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg     <= 1'b0;
            res_reg     <= 31'd65536;
            margin_reg  <= '0;
            inc_reg     <= 13'd1;
            orgx_reg    <= '0;
            orgy_reg    <= '0;
            icol_reg    <= 13'd64;
            irow_reg    <= 13'd64;
            cx_reg      <= '0;
            cy_reg      <= '0;
            ct_reg      <= CW'(64);
            rt_reg      <= CW'(64);
            rev_reg     <= 32'd1;
            state_reg   <= ST_IDLE;
            run_reg     <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    gel_pkg::REG_EXPANDABLE: exp_reg <= pwdata[0];
                    gel_pkg::REG_RESOLUTION: res_reg <= pwdata[30:0];
                    gel_pkg::REG_MARGIN:     margin_reg <= pwdata[30:0];
                    gel_pkg::REG_INCREMENT:  inc_reg <= pwdata[12:0];
                    gel_pkg::REG_ORIGIN_X: begin
                        orgx_reg <= pwdata;
                        cx_reg   <= $signed(pwdata);
                    end
                    gel_pkg::REG_ORIGIN_Y: begin
                        orgy_reg <= pwdata;
                        cy_reg   <= $signed(pwdata);
                    end
                    gel_pkg::REG_INIT_COLS: begin
                        icol_reg <= pwdata[12:0];
                        ct_reg   <= CW'(pwdata[12:0]);
                    end
                    gel_pkg::REG_INIT_ROWS: begin
                        irow_reg <= pwdata[12:0];
                        rt_reg   <= CW'(pwdata[12:0]);
                    end
                    default: exp_reg <= exp_reg;
                endcase
            end

            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            // Shared unit: shift-add multiply or restoring divide, one bit a cycle.
            if (run_reg && (cnt_reg != '0)) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (mode_mul_reg) begin
                    if (opb_reg[0]) begin
                        acc_reg <= acc_reg + opa_reg;
                    end
                    opa_reg <= {opa_reg[AW-2:0], 1'b0};
                    opb_reg <= {1'b0, opb_reg[QW-1:1]};
                end else begin
                    acc_reg <= div_ge ? AW'(div_r2 - {1'b0, opa_reg[30:0]}) : AW'(div_r2);
                    opb_reg <= {opb_reg[QW-2:0], div_ge};
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        px_reg    <= s_data.point_x;
                        py_reg    <= s_data.point_y;
                        state_reg <= ST_MAXX;
                    end
                end
                ST_EVAL: begin
                    k_reg <= 2'd0;
                    if (!exp_reg) begin
                        outcome_reg <= pt_in ? gel_pkg::OC_UNCHANGED : gel_pkg::OC_FIXED_REJ;
                        state_reg   <= ST_LMAXX;
                    end else begin
                        outcome_reg <= gel_pkg::OC_UNCHANGED;
                        amt_reg[0]  <= cxe + mxe - pxe;
                        amt_reg[1]  <= pxe + mxe - maxx_reg;
                        amt_reg[2]  <= cye + mxe - pye;
                        amt_reg[3]  <= pye + mxe - maxy_reg;
                        state_reg   <= ST_NEED;
                    end
                end
                ST_SUM: begin
                    nc_reg <= nc_sum;
                    nr_reg <= nr_sum;
                    if (!any_cells) begin
                        state_reg <= ST_LMAXX;
                    end else if ((nc_sum > LIM_COLS) || (nr_sum > LIM_ROWS)) begin
                        outcome_reg <= gel_pkg::OC_LIMIT_REJ;
                        state_reg   <= ST_LMAXX;
                    end else begin
                        state_reg <= ST_AREA;
                    end
                end
                ST_COMMIT: begin
                    if ((nx_reg < CORNER_MIN) || (ny_reg < CORNER_MIN)) begin
                        outcome_reg <= gel_pkg::OC_LIMIT_REJ;
                    end else begin
                        cx_reg      <= nx_reg[31:0];
                        cy_reg      <= ny_reg[31:0];
                        ct_reg      <= nc_reg[CW-1:0];
                        rt_reg      <= nr_reg[CW-1:0];
                        rev_reg     <= rev_reg + 32'd1;
                        outcome_reg <= gel_pkg::OC_EXPANDED;
                    end
                    state_reg <= ST_LMAXX;
                end
                ST_LCHK: begin
                    if (pt_in) begin
                        state_reg <= ST_COL;
                    end else begin
                        cv_reg    <= 1'b0;
                        ci_reg    <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                 <= 1'b1;
                        m_data_reg.outcome          <= outcome_reg;
                        m_data_reg.cell_valid       <= cv_reg;
                        m_data_reg.cell_index       <= ci_reg;
                        m_data_reg.grid_columns     <= ct_reg[12:0];
                        m_data_reg.grid_rows        <= rt_reg[12:0];
                        m_data_reg.grid_min_x       <= cx_reg;
                        m_data_reg.grid_min_y       <= cy_reg;
                        m_data_reg.grid_revision    <= rev_reg;
                        state_reg                   <= ST_IDLE;
                    end
                end
                ST_NEED: begin
                    if (!run_reg && (amt_reg[k_reg] <= 0)) begin
                        cells_reg[k_reg] <= '0;
                        k_reg            <= k_reg + 2'd1;
                        if (k_reg == 2'd3) begin
                            state_reg <= ST_SUM;
                        end
                    end else if (!run_reg) begin
                        run_reg      <= 1'b1;
                        mode_mul_reg <= ld_mul;
                        cnt_reg      <= 6'(gel_pkg::DIV_STEPS);
                        acc_reg      <= '0;
                        opa_reg      <= AW'(ld_b);
                        opb_reg      <= ld_a[QW-1:0];
                    end else if (done) begin
                        run_reg   <= 1'b0;
                        tmp_reg   <= opb_reg;
                        state_reg <= ST_ROUND;
                    end
                end
                default: begin
                    // Operation states: start the shared unit, then take its result.
                    if (!run_reg) begin
                        run_reg      <= 1'b1;
                        mode_mul_reg <= ld_mul;
                        cnt_reg      <= ld_mul ? 6'(gel_pkg::MUL_STEPS) : 6'(gel_pkg::DIV_STEPS);
                        acc_reg      <= '0;
                        opa_reg      <= ld_mul ? ld_a : AW'(ld_b);
                        opb_reg      <= ld_mul ? QW'(ld_b) : ld_a[QW-1:0];
                    end else if (done) begin
                        run_reg <= 1'b0;
                        case (state_reg)
                            ST_MAXX: begin
                                maxx_reg  <= cxe + $signed({2'b00, acc_reg});
                                state_reg <= ST_MAXY;
                            end
                            ST_MAXY: begin
                                maxy_reg  <= cye + $signed({2'b00, acc_reg});
                                state_reg <= ST_EVAL;
                            end
                            ST_ROUND: begin
                                tmp_reg   <= opb_reg;
                                state_reg <= ST_SCALE;
                            end
                            ST_SCALE: begin
                                cells_reg[k_reg] <= acc_reg[QW-1:0];
                                k_reg            <= k_reg + 2'd1;
                                state_reg        <= (k_reg == 2'd3) ? ST_SUM : ST_NEED;
                            end
                            ST_AREA: begin
                                if (acc_reg > LIM_CELLS) begin
                                    outcome_reg <= gel_pkg::OC_LIMIT_REJ;
                                    state_reg   <= ST_LMAXX;
                                end else begin
                                    state_reg <= ST_SHX;
                                end
                            end
                            ST_SHX: begin
                                nx_reg    <= cxe - $signed({2'b00, acc_reg});
                                state_reg <= ST_SHY;
                            end
                            ST_SHY: begin
                                ny_reg    <= cye - $signed({2'b00, acc_reg});
                                state_reg <= ST_COMMIT;
                            end
                            ST_LMAXX: begin
                                maxx_reg  <= cxe + $signed({2'b00, acc_reg});
                                state_reg <= ST_LMAXY;
                            end
                            ST_LMAXY: begin
                                maxy_reg  <= cye + $signed({2'b00, acc_reg});
                                state_reg <= ST_LCHK;
                            end
                            ST_COL: begin
                                col_reg   <= opb_reg;
                                state_reg <= ST_ROW;
                            end
                            ST_ROW: begin
                                tmp_reg   <= opb_reg;
                                state_reg <= ST_IDX;
                            end
                            ST_IDX: begin
                                if ((col_reg < QW'(ct_reg)) && (tmp_reg < QW'(rt_reg))) begin
                                    cv_reg <= 1'b1;
                                    ci_reg <= idx_sum[23:0];
                                end else begin
                                    cv_reg <= 1'b0;
                                    ci_reg <= '0;
                                end
                                state_reg <= ST_OUT;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_rev_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (rev_reg != $past(rev_reg))) |->
            ((rev_reg == $past(rev_reg) + 32'd1) && ($past(state_reg) == ST_COMMIT)))
        else $error("revision changed outside a grid commit");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("waiting result changed or dropped");
    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.cell_valid) |-> (m_data.cell_index == '0))
        else $error("invalid cell with nonzero index");
    a_unit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> (state_reg != ST_IDLE) && (state_reg != ST_OUT))
        else $error("shared unit running outside an operation");
`endif

endmodule

// ----- sim/grid_expand_and_locate_test.sv -----
// Testbench for the grid expansion and point locate block, with a grid model scoreboard.
`timescale 1ns / 1ps

module grid_expand_and_locate_test;
    import gel_pkg::*;

    class grid_scoreboard;
        bit         expandable;
        longint     resolution;
        longint     margin;
        longint     increment;
        longint     corner_x;
        longint     corner_y;
        longint     columns;
        longint     rows;
        bit [31:0]  revision;
        out_t       pending[$];
        int         mismatches;

        function void reset_state();
            expandable = 0;
            resolution = 65536;
            margin = 0;
            increment = 1;
            corner_x = 0;
            corner_y = 0;
            columns = 64;
            rows = 64;
            revision = 1;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_EXPANDABLE: expandable = value[0];
                REG_RESOLUTION: resolution = value[30:0];
                REG_MARGIN:     margin = value[30:0];
                REG_INCREMENT:  increment = value[12:0];
                REG_ORIGIN_X:   corner_x = $signed(value);
                REG_ORIGIN_Y:   corner_y = $signed(value);
                REG_INIT_COLS:  columns = value[12:0];
                REG_INIT_ROWS:  rows = value[12:0];
                default: ;
            endcase
        endfunction

        function longint cells_to_cover(longint amount);
            longint res, chunk, need;
            res = (resolution == 0) ? 1 : resolution;
            chunk = (increment == 0) ? 1 : increment;
            if (amount <= 0) return 0;
            need = (amount + res - 1) / res;
            return ((need + chunk - 1) / chunk) * chunk;
        endfunction

        function void note_request(in_t req);
            longint px, py, res, maxx, maxy, lf, rt, bt, tp, nc, nr, nx, ny, col, row;
            bit refuse;
            out_t r;
            px = req.point_x;
            py = req.point_y;
            res = (resolution == 0) ? 1 : resolution;
            maxx = corner_x + columns * res;
            maxy = corner_y + rows * res;
            r = '0;
            r.outcome = OC_UNCHANGED;
            if (!expandable) begin
                if (!(px >= corner_x && py >= corner_y && px < maxx && py < maxy))
                    r.outcome = OC_FIXED_REJ;
            end else if (!(px >= corner_x + margin && py >= corner_y + margin &&
                           px < maxx - margin && py < maxy - margin)) begin
                lf = cells_to_cover(corner_x + margin - px);
                rt = cells_to_cover(px + margin - maxx);
                bt = cells_to_cover(corner_y + margin - py);
                tp = cells_to_cover(py + margin - maxy);
                if (lf != 0 || rt != 0 || bt != 0 || tp != 0) begin
                    nc = columns + lf + rt;
                    nr = rows + bt + tp;
                    refuse = nc > 4096 || nr > 4096;
                    if (!refuse) refuse = nc * nr > 16777216;
                    if (!refuse) begin
                        nx = corner_x - lf * res;
                        ny = corner_y - bt * res;
                        refuse = nx < -64'sd2147483648 || ny < -64'sd2147483648;
                    end
                    if (refuse) begin
                        r.outcome = OC_LIMIT_REJ;
                    end else begin
                        corner_x = nx;
                        corner_y = ny;
                        columns = nc;
                        rows = nr;
                        revision = revision + 1;
                        r.outcome = OC_EXPANDED;
                    end
                end
            end
            maxx = corner_x + columns * res;
            maxy = corner_y + rows * res;
            if (px >= corner_x && py >= corner_y && px < maxx && py < maxy) begin
                col = (px - corner_x) / res;
                row = (py - corner_y) / res;
                if (col < columns && row < rows) begin
                    r.cell_valid = 1;
                    r.cell_index = 24'(row * columns + col);
                end
            end
            r.grid_columns = 13'(columns);
            r.grid_rows = 13'(rows);
            r.grid_min_x = 32'(corner_x);
            r.grid_min_y = 32'(corner_y);
            r.grid_revision = revision;
            pending.push_back(r);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_t        m_data;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    grid_scoreboard board = new();
    int  idle_cycles = 0;
    bit  hold_receiver = 0;
    bit  sending_done = 0;

    grid_expand_and_locate dut (.*);

    always #10 aclk = ~aclk;

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : receiver
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_receiver) begin
                m_ready <= 0;
                repeat (3000) @(posedge aclk);
                hold_receiver = 0;
            end
            n = gap_length();
            if (n > 0) begin
                m_ready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        board.write_reg(idx, value);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y);
        int n;
        n = gap_length();
        if (n > 0) begin
            s_valid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= {x, y};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(s_data);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
    endtask

    task automatic configure(bit exp, logic [31:0] res, logic [31:0] mar, logic [31:0] inc,
                             logic [31:0] ox, logic [31:0] oy, logic [31:0] nc,
                             logic [31:0] nr);
        write_reg(REG_EXPANDABLE, exp);
        write_reg(REG_RESOLUTION, res);
        write_reg(REG_MARGIN, mar);
        write_reg(REG_INCREMENT, inc);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_INIT_COLS, nc);
        write_reg(REG_INIT_ROWS, nr);
    endtask

    function automatic logic [31:0] near_coord(longint base, longint span);
        longint v;
        v = base + $signed($urandom_range(0, 2 * span + 2 * 65536 * 4)) - 65536 * 4;
        if ($urandom_range(0, 9) == 0) v = $signed($urandom());
        return 32'(v);
    endfunction

    task automatic random_phase(int count);
        longint res;
        repeat (count) begin
            res = (board.resolution == 0) ? 1 : board.resolution;
            if ($urandom_range(0, 3) == 0)
                send_point($urandom(), $urandom());
            else
                send_point(near_coord(board.corner_x, board.columns * res),
                           near_coord(board.corner_y, board.rows * res));
        end
    endtask

    initial begin
        board.reset_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h003F_FFFF, 32'h003F_FFFF);
        send_point(32'h0040_0000, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0010_0000);
        drain();
        configure(1, 0, 0, 0, 32'h0000_0000, 32'h0000_0000, 4, 4);
        send_point(32'h0000_0010, 32'hFFFF_FFF0);
        send_point(32'h0000_0002, 32'h0000_0001);
        drain();
        configure(1, 65536, 65536 * 2, 4, 32'h8000_1000, 32'h0, 16, 16);
        send_point(32'h8000_0000, 32'h0008_0000);
        send_point(32'h0008_0000, 32'h0008_0000);
        send_point(32'h0100_0000, 32'h0200_0000);
        drain();
        configure(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4096, 32'h0, 32'h0, 1, 1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0, 32'h0);
        drain();
        configure(0, 65536, 0, 1, 32'h0, 32'h0, 0, 4096);
        send_point(32'h0, 32'h0);
        drain();
        configure(1, 65536, 0, 1, 32'h0, 32'h0, 4096, 4096);
        send_point(32'hFFFF_0000, 32'h10);
        send_point(32'h0FFF_0000, 32'h0FFF_0000);
        drain();

        configure(1, 65536, 65536, 1, 32'hFFF0_0000, 32'h0010_0000, 8, 8);
        random_phase(300);
        fork
            begin
                hold_receiver = 1;
                random_phase(10);
            end
        join
        drain();
        configure(0, 4096, 0, 0, 32'h1234_0000, 32'hFFFF_8000, 100, 50);
        random_phase(300);
        drain();
        configure(1, 1 + $urandom_range(0, 65536 * 8), $urandom_range(0, 65536 * 4),
                  $urandom_range(0, 16), $urandom(), $urandom(), 1 + $urandom_range(0, 200),
                  1 + $urandom_range(0, 200));
        random_phase(300);
        drain();
        configure(1, 32'h0100_0000, 32'h0080_0000, 2, 32'h0, 32'h0, 2, 2);
        random_phase(300);
        drain();
        configure(1, 300, 700, 3, 32'h7FFF_0000, 32'h8000_0000, 4000, 30);
        random_phase(280);
        drain();
        sending_done = 1;

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
